FILE: src/ordered_list_engine_macros.svh
// Assertion macros shared by the ordered list engine checkers.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// same-cycle implication
`define OLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ole_pkg.sv
// Shared types and constants of the ordered list engine.
// No dependencies.
`default_nettype none

package ole_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int VAL_W        = 32;
  localparam int OP_W         = 3;
  localparam int ST_W         = 2;
  localparam int OCC_W        = 6;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT  = 3'd0,
    OP_INS_END    = 3'd1,
    OP_INS_SORTED = 3'd2,
    OP_DEL_FRONT  = 3'd3,
    OP_DEL_END    = 3'd4,
    OP_READ_ALL   = 3'd5
  } opcode_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic    cmp;        // evaluate insert position flags
    logic    ins_apply;  // open a slot at the flagged position
    logic    shift_left; // drop the head
    logic    rotate;     // move toward the head, head wraps to the tail
    opcode_e op;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: src/ordered_list_engine.sv
// Ordered list engine: list cell chain plus operation sequencer. Needs ole_pkg, ole_cell.
// From accept: inserts pass S_CMP and S_APPLY before the registered strobe, deletes and
// errors pass S_CMP only, read-all passes S_CMP and then gives one word per cycle in S_READ.
// A new item is taken only in S_IDLE, once the last one is through; busy is high while an
// item is in work. The receiver cannot stall.
// Reset empties the list; stored words are not cleared.
`default_nettype none

module ordered_list_engine #(
  parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic        [ole_pkg::OP_W-1:0]   opcode_i,
  input  wire logic signed [ole_pkg::VAL_W-1:0]  value_i,
  output logic                                   result_valid_o,
  output logic signed [ole_pkg::VAL_W-1:0]       item_value_o,
  output logic        [ole_pkg::ST_W-1:0]        status_o,
  output logic                                   last_o,
  output logic        [ole_pkg::OCC_W-1:0]       occupancy_o
);
  import ole_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY,
    S_READ
  } state_e;

  state_e                  state_q;
  opcode_e                 op_q;
  logic signed [VAL_W-1:0] val_q;
  logic [CNT_W-1:0]        count_q, rd_cnt_q;
  logic                    strobe_q, last_q;
  logic signed [VAL_W-1:0] item_q;
  status_e                 status_q;
  logic [OCC_W-1:0]        occ_q;

  cell_ctrl_t              ctrl;
  logic signed [VAL_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY:0]       seen;
  logic signed [VAL_W-1:0] tail_data;
  logic                    empty, full;

  assign empty = count_q == '0;
  assign full  = count_q == CapCnt;

  always_comb begin
    ctrl.cmp        = state_q == S_CMP;
    ctrl.ins_apply  = state_q == S_APPLY;
    ctrl.shift_left = (state_q == S_CMP) && (op_q == OP_DEL_FRONT) && !empty;
    ctrl.rotate     = state_q == S_READ;
    ctrl.op         = op_q;
  end

  assign seen[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VAL_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_lastc
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = cell_data[g+1];
    end

    ole_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .value_i (val_q),
      .count_i (count_q),
      .left_i  (left_w),
      .right_i (right_w),
      .head_i  (cell_data[0]),
      .seen_i  (seen[g]),
      .seen_o  (seen[g+1]),
      .data_o  (cell_data[g])
    );
  end

  always_comb begin
    tail_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CNT_W'(i) == (count_q - 1'b1)) begin
        tail_data = tail_data | cell_data[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= OP_INS_FRONT;
      val_q    <= '0;
      count_q  <= '0;
      rd_cnt_q <= '0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
      item_q   <= '0;
      status_q <= ST_OK;
      occ_q    <= '0;
    end else begin
      strobe_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            op_q    <= opcode_e'(opcode_i);
            val_q   <= value_i;
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          strobe_q <= 1'b1;
          last_q   <= 1'b1;
          item_q   <= '0;
          status_q <= ST_OK;
          occ_q    <= OCC_W'(count_q);
          state_q  <= S_IDLE;
          case (op_q)
            OP_INS_FRONT, OP_INS_END, OP_INS_SORTED: begin
              if (full) begin
                status_q <= ST_FULL;
              end else begin
                strobe_q <= 1'b0;
                state_q  <= S_APPLY;
              end
            end
            OP_DEL_FRONT, OP_DEL_END: begin
              if (empty) begin
                status_q <= ST_EMPTY;
              end else begin
                item_q  <= (op_q == OP_DEL_FRONT) ? cell_data[0] : tail_data;
                count_q <= count_q - 1'b1;
                occ_q   <= OCC_W'(count_q - 1'b1);
              end
            end
            OP_READ_ALL: begin
              if (empty) begin
                status_q <= ST_EMPTY;
              end else begin
                strobe_q <= 1'b0;
                rd_cnt_q <= '0;
                state_q  <= S_READ;
              end
            end
            default: ;
          endcase
        end
        S_APPLY: begin
          count_q  <= count_q + 1'b1;
          strobe_q <= 1'b1;
          last_q   <= 1'b1;
          item_q   <= '0;
          status_q <= ST_OK;
          occ_q    <= OCC_W'(count_q + 1'b1);
          state_q  <= S_IDLE;
        end
        S_READ: begin
          strobe_q <= 1'b1;
          item_q   <= cell_data[0];
          status_q <= ST_OK;
          occ_q    <= OCC_W'(count_q);
          rd_cnt_q <= rd_cnt_q + 1'b1;
          if (rd_cnt_q == (count_q - 1'b1)) begin
            last_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            last_q  <= 1'b0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy           = state_q != S_IDLE;
  assign result_valid_o = strobe_q;
  assign item_value_o   = item_q;
  assign status_o       = status_q;
  assign last_o         = last_q;
  assign occupancy_o    = occ_q;

endmodule

`default_nettype wire

FILE: src/ole_cell.sv
// One list cell: holds one word and its insert-position flag.
// Depends on ole_pkg.
`default_nettype none

module ole_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 6
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire ole_pkg::cell_ctrl_t               ctrl_i,
  input  wire logic signed [ole_pkg::VAL_W-1:0]  value_i,
  input  wire logic        [CNT_W-1:0]           count_i,
  input  wire logic signed [ole_pkg::VAL_W-1:0]  left_i,
  input  wire logic signed [ole_pkg::VAL_W-1:0]  right_i,
  input  wire logic signed [ole_pkg::VAL_W-1:0]  head_i,
  input  wire logic                              seen_i,
  output logic                                   seen_o,
  output logic signed [ole_pkg::VAL_W-1:0]       data_o
);
  import ole_pkg::*;

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  logic signed [VAL_W-1:0] data_q, data_d;
  logic                    hit_q, hit_d;
  logic                    is_valid, is_end, is_tail, lt_v;

  assign is_valid = MyIdx < count_i;
  assign is_end   = MyIdx == count_i;
  assign is_tail  = MyIdx == (count_i - 1'b1);
  assign lt_v     = data_q < value_i;

  always_comb begin
    hit_d = hit_q;
    if (ctrl_i.cmp) begin
      case (ctrl_i.op)
        OP_INS_FRONT:  hit_d = (IDX == 0);
        OP_INS_END:    hit_d = is_end;
        OP_INS_SORTED: begin
          if (IDX == 0) begin
            hit_d = is_end || (value_i < data_q);
          end else begin
            hit_d = (is_valid && !lt_v) || is_end;
          end
        end
        default:       hit_d = 1'b0;
      endcase
    end
  end

  assign seen_o = seen_i | hit_q;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins_apply) begin
      if (seen_i) begin
        data_d = left_i;
      end else if (hit_q) begin
        data_d = value_i;
      end
    end else if (ctrl_i.shift_left) begin
      data_d = right_i;
    end else if (ctrl_i.rotate) begin
      data_d = is_tail ? head_i : right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

FILE: src/ole_checker.sv
// Port-level checks of the ordered list engine, bound to the top level.
// Depends on ole_pkg and ordered_list_engine_macros.svh.
`default_nettype none

`include "ordered_list_engine_macros.svh"

module ole_checker #(
  parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic                              result_valid_o,
  input wire logic signed [ole_pkg::VAL_W-1:0]  item_value_o,
  input wire logic        [ole_pkg::ST_W-1:0]   status_o,
  input wire logic                              last_o,
  input wire logic        [ole_pkg::OCC_W-1:0]  occupancy_o
);
  import ole_pkg::*;

  localparam logic [OCC_W-1:0] CapOcc = OCC_W'(CAPACITY);

  `OLE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `OLE_ASSERT_NOW(a_last_idle, result_valid_o && last_o, !busy, "busy after final result")
  `OLE_ASSERT_NEXT(a_stream, result_valid_o && !last_o, result_valid_o, "read stream broke")
  `OLE_ASSERT_NOW(a_full, result_valid_o && status_o == ST_FULL, occupancy_o == CapOcc && item_value_o == '0 && last_o, "bad full result")
  `OLE_ASSERT_NOW(a_empty, result_valid_o && status_o == ST_EMPTY, occupancy_o == '0 && item_value_o == '0 && last_o, "bad empty result")

endmodule

bind ordered_list_engine ole_checker #(.CAPACITY(CAPACITY)) u_ole_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .item_value_o   (item_value_o),
  .status_o       (status_o),
  .last_o         (last_o),
  .occupancy_o    (occupancy_o)
);

`default_nettype wire
